// ===== rtl/hkvc_pkg.sv =====
package hkvc_pkg;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_GET    = 2'd0,
        REQ_SET    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_EXISTS = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISS       = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_FULL       = 3'd3,
        ST_PRESENT    = 3'd4,
        ST_UNGETTABLE = 3'd5
    } t_status;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY   = 1'b0;
    localparam logic CFG_UNGETTABLE = 1'b1;

    localparam logic [31:0] HASH_SEED   = 32'd5381;
    localparam logic [15:0] BUCKET_MASK = 16'hffff;
    localparam int          BUCKET_BITS = 16;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // latch request, start hashing
        OP_HASH,       // fold one key byte
        OP_MOD,        // reduce hash to bucket
        OP_HEAD_RD,    // read bucket head
        OP_SLOT_RD,    // read slot at cursor
        OP_STEP,       // cursor follows next link
        OP_GET_HIT,    // count hit, write back
        OP_ALLOC,      // pick a slot for a set
        OP_WRITE_NEW,  // store the new entry
        OP_LINK,       // link new entry behind tail or as head
        OP_DEL_PREV,   // patch predecessor or bucket head
        OP_DEL_NEXT,   // patch successor, clear slot, free it
        OP_CLEAR       // sweep one bucket entry to zero
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic       bad_klen;
        logic       bad_vlen;
        logic       full;
        logic       hash_done;
        logic       cur_null;
        logic       match;
        logic       next_null;
        logic       ungettable;
        logic       alloc_bad;
        logic       clear_done;
        t_req       req;
    } t_stat;

    // Sign-extended byte fold of the djb33x hash.
    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] ext;
        ext = {{24{b[7]}}, b};
        return ((h << 5) + h) ^ ext;
    endfunction

endpackage

// ===== rtl/hkvc_ctrl.sv =====
module hkvc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_res_load,
    input  logic                 i_out_free,
    input  hkvc_pkg::t_stat      i_stat,
    output hkvc_pkg::t_cmd       o_cmd,
    output hkvc_pkg::t_status    o_status,
    output logic                 o_slot_sel
);
    import hkvc_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_HASH    = 14'b00000000000100,
        S_MOD     = 14'b00000000001000,
        S_HEAD    = 14'b00000000010000,
        S_RD      = 14'b00000000100000,
        S_CHK     = 14'b00000001000000,
        S_GET     = 14'b00000010000000,
        S_ALLOC   = 14'b00000100000000,
        S_WRITE   = 14'b00001000000000,
        S_LINK    = 14'b00010000000000,
        S_DPREV   = 14'b00100000000000,
        S_DNEXT   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    t_status r_status, n_status;
    logic r_sel, n_sel;

    // Main sequencing: hash, head read, chain walk, then the operation.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_sel    = r_sel;
        o_cmd.op = OP_NONE;
        o_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.bad_klen) begin
                    n_status = ST_BAD_LENGTH; n_sel = 1'b0; n_state = S_DONE;
                end else if (i_stat.hash_done) begin
                    n_state = S_MOD;
                end else begin
                    o_cmd.op = OP_HASH;
                end
            end
            S_MOD: begin
                o_cmd.op = OP_MOD;
                if (i_stat.req == REQ_SET && i_stat.bad_vlen) begin
                    n_status = ST_BAD_LENGTH; n_sel = 1'b0; n_state = S_DONE;
                end else if (i_stat.req == REQ_SET && i_stat.full) begin
                    n_status = ST_FULL; n_sel = 1'b0; n_state = S_DONE;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.op = OP_HEAD_RD;
                n_state  = S_RD;
            end
            S_RD: begin
                if (i_stat.cur_null) begin
                    if (i_stat.req == REQ_SET) n_state = S_ALLOC;
                    else begin
                        n_status = ST_MISS; n_sel = 1'b0; n_state = S_DONE;
                    end
                end else begin
                    o_cmd.op = OP_SLOT_RD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.match) begin
                    n_sel = 1'b1;
                    unique case (i_stat.req)
                        REQ_SET:    begin n_status = ST_PRESENT; n_state = S_DONE; end
                        REQ_EXISTS: begin n_status = ST_OK; n_state = S_DONE; end
                        REQ_GET: begin
                            if (i_stat.ungettable) begin
                                n_status = ST_UNGETTABLE; n_state = S_DONE;
                            end else n_state = S_GET;
                        end
                        default: n_state = S_DPREV;
                    endcase
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state  = S_RD;
                end
            end
            S_GET: begin
                o_cmd.op = OP_GET_HIT;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                if (i_stat.alloc_bad) begin
                    n_status = ST_FULL; n_sel = 1'b0; n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_WRITE_NEW;
                    n_state  = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.op = OP_LINK;
                n_status = ST_OK; n_sel = 1'b1;
                n_state  = S_DONE;
            end
            S_DPREV: begin
                o_cmd.op = OP_DEL_PREV;
                n_state  = S_DNEXT;
            end
            S_DNEXT: begin
                o_cmd.op = OP_DEL_NEXT;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_load = (r_state == S_DONE) && i_out_free;
    assign o_status   = r_status;
    assign o_slot_sel = r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_OK;
            r_sel    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_sel    <= n_sel;
        end
    end
endmodule

// ===== rtl/hkvc_datapath.sv =====
module hkvc_datapath #(
    parameter int ITEM_SLOTS    = 1024,
    parameter int MAX_KEY_BYTES = 8,
    parameter int VALUE_BYTES   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hkvc_pkg::t_cmd       i_cmd,
    output hkvc_pkg::t_stat      o_stat,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [1:0]           i_req_type,
    input  logic [63:0]          i_key_bytes,
    input  logic [3:0]           i_key_length,
    input  logic [63:0]          i_value_word,
    input  logic [3:0]           i_value_length,
    input  logic [31:0]          i_lifetime,
    input  logic [31:0]          i_now_time,
    input  logic [15:0]          i_entry_flags,
    input  logic                 i_slot_sel,
    output logic [9:0]           o_slot_index,
    output logic [63:0]          o_read_value,
    output logic [3:0]           o_read_length,
    output logic [31:0]          o_hit_count
);
    import hkvc_pkg::*;

    localparam int SW = $clog2(ITEM_SLOTS);
    localparam int CW = SW + 1;
    localparam int NBUCKETS = 65535;
    localparam logic [CW-1:0] SLOTS_C = CW'(ITEM_SLOTS);

    // Configuration.
    logic [10:0] r_capacity;
    logic [15:0] r_ungettable;

    // Latched request.
    t_req        r_req;
    logic [63:0] r_key;
    logic [3:0]  r_klen;
    logic [63:0] r_val;
    logic [3:0]  r_vlen;
    logic [31:0] r_expiry;
    logic [15:0] r_flags;
    logic [31:0] r_hash;
    logic [3:0]  r_hcnt;
    logic [15:0] r_bucket;

    // Walk and allocation registers.
    logic [SW-1:0] r_cur, r_prev_cur, r_idx, r_del_p, r_del_n;
    logic          r_alloc_bad;
    logic [CW-1:0] r_top, r_hw;
    logic [15:0]   r_clr;

    // Memories.
    logic [SW-1:0] m_heads [NBUCKETS];
    logic [63:0]   m_key   [ITEM_SLOTS];
    logic [3:0]    m_klen  [ITEM_SLOTS];
    logic [31:0]   m_hash  [ITEM_SLOTS];
    logic [63:0]   m_val   [ITEM_SLOTS];
    logic [3:0]    m_vlen  [ITEM_SLOTS];
    logic [31:0]   m_hits  [ITEM_SLOTS];
    logic [15:0]   m_flags [ITEM_SLOTS];
    logic [31:0]   m_exp   [ITEM_SLOTS];
    logic [SW-1:0] m_next  [ITEM_SLOTS];
    logic [SW-1:0] m_prev  [ITEM_SLOTS];
    logic [SW-1:0] m_free  [ITEM_SLOTS];

    // Registered read data of the slot at the cursor.
    logic [63:0]   rd_key, rd_val;
    logic [3:0]    rd_klen, rd_vlen;
    logic [31:0]   rd_hash, rd_hits;
    logic [15:0]   rd_flags;
    logic [SW-1:0] rd_next, rd_prev, rd_head, rd_free;

    logic [63:0] kmask, vmask;
    logic [CW-1:0] eff_cap;
    logic [16:0] hmod;
    logic [15:0] bucket_now;

    always_comb begin
        kmask = (i_key_length >= 4'd8) ? '1 : ((64'd1 << {i_key_length, 3'b000}) - 64'd1);
        vmask = (i_value_length >= 4'd8) ? '1 : ((64'd1 << {i_value_length, 3'b000}) - 64'd1);
        eff_cap = ({1'b0, r_capacity} > 12'(ITEM_SLOTS)) ? SLOTS_C : CW'(r_capacity);
        // x mod 65535: fold the halves, one correction.
        hmod = {1'b0, r_hash[31:16]} + {1'b0, r_hash[15:0]};
        hmod = {1'b0, hmod[15:0]} + {16'd0, hmod[16]};
        bucket_now = (hmod[15:0] == BUCKET_MASK) ? 16'd0 : hmod[15:0];
    end

    // Status toward the controller.
    always_comb begin
        o_stat.bad_klen   = (r_klen == 4'd0) || (r_klen > 4'(MAX_KEY_BYTES));
        o_stat.bad_vlen   = (r_vlen == 4'd0) || (r_vlen > 4'(VALUE_BYTES));
        o_stat.full       = (r_hw >= eff_cap) && (r_top == '0);
        o_stat.hash_done  = (r_hcnt == r_klen);
        o_stat.cur_null   = (r_cur == '0);
        o_stat.match      = (rd_hash == r_hash) && (rd_klen == r_klen) && (rd_key == r_key);
        o_stat.next_null  = (rd_next == '0);
        o_stat.ungettable = (rd_flags & r_ungettable) != 16'd0;
        o_stat.alloc_bad  = r_alloc_bad;
        o_stat.clear_done = (r_clr == 16'(NBUCKETS - 1));
        o_stat.req        = r_req;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= 11'd1024;
            r_ungettable <= 16'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_CAPACITY) r_capacity <= i_cfg_data[10:0];
            else r_ungettable <= i_cfg_data;
        end
    end

    // Control-like state: stack top, high water, clear sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_hw  <= CW'(1);
            r_clr <= '0;
        end else begin
            if (i_cmd.op == OP_CLEAR && r_clr != 16'(NBUCKETS - 1)) r_clr <= r_clr + 16'd1;
            if (i_cmd.op == OP_ALLOC) begin
                if (r_top != '0 && r_top < SLOTS_C) r_top <= r_top - CW'(1);
                else if (r_hw < eff_cap) r_hw <= r_hw + CW'(1);
            end
            if (i_cmd.op == OP_DEL_NEXT) begin
                if (CW'(r_cur) + CW'(1) == r_hw) r_hw <= r_hw - CW'(1);
                else if (r_top + CW'(1) < SLOTS_C) r_top <= r_top + CW'(1);
            end
        end
    end

    // Bucket heads memory: one port, registered read.
    // A deleted head hands the bucket to its successor straight from the slot read.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CLEAR:    m_heads[r_clr] <= '0;
            OP_LINK:     if (rd_head == '0) m_heads[r_bucket] <= r_idx;
            OP_DEL_PREV: if (rd_prev == '0) m_heads[r_bucket] <= rd_next;
            default: rd_head <= m_heads[bucket_now];
        endcase
    end

    // Free stack memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DEL_NEXT && CW'(r_cur) + CW'(1) != r_hw
            && r_top + CW'(1) < SLOTS_C)
            m_free[r_top[SW-1:0] + SW'(1)] <= r_cur;
        rd_free <= m_free[r_top[SW-1:0]];
    end

    // Request latch, hashing and the walk cursor.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_req    <= t_req'(i_req_type);
                r_key    <= i_key_bytes & kmask;
                r_klen   <= i_key_length;
                r_val    <= i_value_word & vmask;
                r_vlen   <= i_value_length;
                r_expiry <= (i_lifetime != 32'd0) ? i_now_time + i_lifetime : 32'd0;
                r_flags  <= i_entry_flags;
                r_hash   <= HASH_SEED;
                r_hcnt   <= 4'd0;
            end
            OP_HASH: begin
                r_hash <= hash_step(r_hash, r_key[{r_hcnt[2:0], 3'b000} +: 8]);
                r_hcnt <= r_hcnt + 4'd1;
            end
            OP_MOD: r_bucket <= bucket_now;
            OP_HEAD_RD: begin
                r_cur      <= rd_head;
                r_prev_cur <= '0;
            end
            OP_STEP: begin
                r_prev_cur <= r_cur;
                r_cur      <= rd_next;
            end
            OP_ALLOC: begin
                if (r_top != '0 && r_top < SLOTS_C) begin
                    r_idx <= rd_free;
                    r_alloc_bad <= (rd_free == '0);
                end else begin
                    r_idx <= r_hw[SW-1:0];
                    r_alloc_bad <= (r_hw == '0) || (r_hw >= SLOTS_C);
                end
            end
            // The cursor then points at the new entry for the result.
            OP_LINK: r_cur <= r_idx;
            OP_DEL_PREV: begin
                r_del_p <= rd_prev;
                r_del_n <= rd_next;
            end
            default: ;
        endcase
    end

    // Slot memories: a whole-slot write plus a link write to a second slot, registered read at the cursor.
    logic          we;
    logic [SW-1:0] wa;
    logic [63:0]   wkey, wval;
    logic [3:0]    wklen, wvlen;
    logic [31:0]   whash, whits;
    logic [15:0]   wflags;
    logic [SW-1:0] wnext, wprev;
    logic          we_next_only, we_prev_only;
    logic [SW-1:0] wa2;

    always_comb begin
        we = 1'b0; wa = r_cur;
        wkey = rd_key; wval = rd_val; wklen = rd_klen; wvlen = rd_vlen;
        whash = rd_hash; whits = rd_hits; wflags = rd_flags;
        wnext = rd_next; wprev = rd_prev;
        we_next_only = 1'b0; we_prev_only = 1'b0; wa2 = '0;
        case (i_cmd.op)
            OP_GET_HIT: begin
                we = 1'b1; whits = rd_hits + 32'd1;
            end
            OP_WRITE_NEW: begin
                we = 1'b1; wa = r_idx;
                wkey = r_key; wval = r_val; wklen = r_klen; wvlen = r_vlen;
                whash = r_hash; whits = '0; wflags = r_flags;
                wnext = '0; wprev = (rd_head == '0) ? '0 : r_prev_cur;
            end
            OP_LINK: begin
                we_next_only = (rd_head != '0);
                wa2 = r_prev_cur;
            end
            OP_DEL_PREV: begin
                we_next_only = (rd_prev != '0);
                wa2 = rd_prev;
            end
            OP_DEL_NEXT: begin
                we = 1'b1; wklen = '0; wvlen = '0; whash = '0; wnext = '0; wprev = '0;
                we_prev_only = (r_del_n != '0);
                wa2 = r_del_n;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            m_key[wa] <= wkey; m_val[wa] <= wval; m_klen[wa] <= wklen;
            m_vlen[wa] <= wvlen; m_hash[wa] <= whash; m_hits[wa] <= whits;
            m_flags[wa] <= wflags;
            m_next[wa] <= wnext; m_prev[wa] <= wprev;
        end
        // Expiry is only ever stored with a new entry.
        if (i_cmd.op == OP_WRITE_NEW)
            m_exp[r_idx] <= r_expiry;
        if (we_next_only)
            m_next[wa2] <= (i_cmd.op == OP_LINK) ? r_idx : rd_next;
        if (we_prev_only)
            m_prev[wa2] <= r_del_p;
        if (i_cmd.op == OP_SLOT_RD) begin
            rd_key <= m_key[r_cur]; rd_val <= m_val[r_cur]; rd_klen <= m_klen[r_cur];
            rd_vlen <= m_vlen[r_cur]; rd_hash <= m_hash[r_cur]; rd_hits <= m_hits[r_cur];
            rd_flags <= m_flags[r_cur]; rd_next <= m_next[r_cur]; rd_prev <= m_prev[r_cur];
        end
        if (i_cmd.op == OP_GET_HIT) rd_hits <= rd_hits + 32'd1;
    end

    // Result fields; value fields only for a successful get.
    always_comb begin
        o_slot_index  = '0;
        o_read_value  = '0;
        o_read_length = '0;
        o_hit_count   = '0;
        if (i_slot_sel) o_slot_index = 10'(r_cur);
        if (i_slot_sel && r_req == REQ_GET && !o_stat.ungettable) begin
            o_read_value  = rd_val;
            o_read_length = rd_vlen;
            o_hit_count   = rd_hits;
        end
    end
endmodule

// ===== rtl/hashed_key_value_cache.sv =====
// Channel | Direction | Handshake          | Payload
// request | in        | i_valid / o_ready  | i_req_type .. i_entry_flags
// result  | out       | o_valid / i_ready  | o_status .. o_hit_count
// config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One request at a time: key hashing, bucket reduction and head read, then a
// slot memory read and a compare per chain entry walked.
// Sets and deletes add write steps after the walk. After reset a clearing pass
// zeroes the 65535 bucket heads, one per cycle, before the first request.
// A waiting result sits in the output register while the next request starts.
module hashed_key_value_cache #(
    parameter int ITEM_SLOTS    = 1024,
    parameter int MAX_KEY_BYTES = 8,
    parameter int VALUE_BYTES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [63:0] i_value_word,
    input  logic [3:0]  i_value_length,
    input  logic [31:0] i_lifetime,
    input  logic [31:0] i_now_time,
    input  logic [15:0] i_entry_flags,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_slot_index,
    output logic [63:0] o_read_value,
    output logic [3:0]  o_read_length,
    output logic [31:0] o_hit_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import hkvc_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_status st;
    logic    sel, res_load, out_free;
    logic [9:0]  slot;
    logic [63:0] rval;
    logic [3:0]  rlen;
    logic [31:0] hits;

    logic        r_valid;
    logic [2:0]  r_status;
    logic [9:0]  r_slot;
    logic [63:0] r_rval;
    logic [3:0]  r_rlen;
    logic [31:0] r_hits;

    assign out_free = !r_valid || i_ready;

    hkvc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_res_load(res_load), .i_out_free(out_free), .i_stat(stat), .o_cmd(cmd),
        .o_status(st), .o_slot_sel(sel)
    );

    hkvc_datapath #(
        .ITEM_SLOTS(ITEM_SLOTS), .MAX_KEY_BYTES(MAX_KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_type(i_req_type), .i_key_bytes(i_key_bytes), .i_key_length(i_key_length),
        .i_value_word(i_value_word), .i_value_length(i_value_length),
        .i_lifetime(i_lifetime), .i_now_time(i_now_time), .i_entry_flags(i_entry_flags),
        .i_slot_sel(sel), .o_slot_index(slot), .o_read_value(rval),
        .o_read_length(rlen), .o_hit_count(hits)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= st;
            r_slot   <= slot;
            r_rval   <= rval;
            r_rlen   <= rlen;
            r_hits   <= hits;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot;
    assign o_read_value  = r_rval;
    assign o_read_length = r_rlen;
    assign o_hit_count   = r_hits;
endmodule

// ===== rtl/hkvc_checker.sv =====
module hkvc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_status,
    input logic [9:0] o_slot_index
);
    import hkvc_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");

    // Status stays in its code range.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_UNGETTABLE)
        else $error("status out of range");

    // Miss and bad-length results carry no slot.
    a_noslot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_MISS || o_status == ST_BAD_LENGTH) |-> o_slot_index == '0)
        else $error("slot on a miss");

    // An accepted request is not answered in the very next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result too early");
endmodule

bind hashed_key_value_cache hkvc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status), .o_slot_index(o_slot_index)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

import hkvc_pkg::*;

// Expected-result store with a predictor of the cache state.
class cache_scoreboard;
    logic [9:0]  heads [int];
    logic [63:0] s_key [1024];
    logic [3:0]  s_klen [1024];
    logic [31:0] s_hash [1024];
    logic [63:0] s_val [1024];
    logic [3:0]  s_vlen [1024];
    logic [31:0] s_hits [1024];
    logic [15:0] s_flags [1024];
    logic [9:0]  s_next [1024];
    logic [9:0]  s_prev [1024];
    logic [9:0]  free_slots [1024];
    int unsigned free_top;
    int unsigned high_water;
    int unsigned capacity;
    logic [15:0] ungettable_mask;
    logic [2:0]  exp_status [$];
    logic [9:0]  exp_slot [$];
    logic [63:0] exp_value [$];
    logic [3:0]  exp_length [$];
    logic [31:0] exp_hits [$];
    int mismatches;
    int results_seen;
    int live_entries;

    function void clear_state();
        heads.delete();
        for (int i = 0; i < 1024; i++) begin
            s_klen[i] = 0; s_hash[i] = 0; s_vlen[i] = 0; s_hits[i] = 0;
            s_flags[i] = 0; s_next[i] = 0; s_prev[i] = 0; s_key[i] = 0; s_val[i] = 0;
        end
        free_top = 0;
        high_water = 1;
        capacity = 1024;
        ungettable_mask = 16'd2;
        live_entries = 0;
    endfunction

    function logic [63:0] bytes_mask(int n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
    endfunction

    function logic [31:0] djb_hash(logic [63:0] k, int n);
        logic [31:0] h;
        logic [31:0] b;
        h = 32'd5381;
        for (int i = 0; i < n; i++) begin
            b = {{24{k[8*i+7]}}, k[8*i +: 8]};
            h = ((h << 5) + h) ^ b;
        end
        return h;
    endfunction

    function int bucket_of(logic [31:0] h);
        return h % 32'hffff;
    endfunction

    function int find_entry(logic [63:0] k, logic [3:0] n, logic [31:0] h);
        int cur;
        cur = heads.exists(bucket_of(h)) ? heads[bucket_of(h)] : 0;
        for (int s = 0; s < 1024; s++) begin
            if (cur == 0) return 0;
            if (s_hash[cur] == h && s_klen[cur] == n && s_key[cur] == k) return cur;
            cur = s_next[cur];
        end
        return 0;
    endfunction

    // Predict the result of one accepted request and queue it.
    function void note_request(t_req req, logic [63:0] kb, logic [3:0] kl,
                               logic [63:0] vw, logic [3:0] vl, logic [15:0] fl);
        logic [2:0]  st;
        logic [9:0]  slot;
        logic [63:0] rv;
        logic [3:0]  rl;
        logic [31:0] rh;
        logic [63:0] k;
        logic [31:0] h;
        int f, idx, cap, b, tail, p, n;
        st = ST_MISS; slot = 0; rv = 0; rl = 0; rh = 0;
        cap = (capacity > 1024) ? 1024 : capacity;
        if (kl == 0 || kl > 8) begin
            st = ST_BAD_LENGTH;
        end else begin
            k = kb & bytes_mask(kl);
            h = djb_hash(k, kl);
            f = find_entry(k, kl, h);
            if (req == REQ_SET) begin
                if (vl == 0 || vl > 8) begin
                    st = ST_BAD_LENGTH;
                end else if (high_water >= cap && free_top == 0) begin
                    st = ST_FULL;
                end else if (f != 0) begin
                    st = ST_PRESENT; slot = 10'(f);
                end else begin
                    if (free_top != 0) begin
                        idx = free_slots[free_top];
                        free_top--;
                    end else begin
                        idx = high_water;
                        if (high_water < cap) high_water++;
                    end
                    s_hash[idx] = h; s_hits[idx] = 0; s_flags[idx] = fl;
                    s_key[idx] = k; s_val[idx] = vw & bytes_mask(vl);
                    s_vlen[idx] = vl; s_klen[idx] = kl;
                    s_next[idx] = 0; s_prev[idx] = 0;
                    b = bucket_of(h);
                    if (!heads.exists(b) || heads[b] == 0) begin
                        heads[b] = 10'(idx);
                    end else begin
                        tail = heads[b];
                        while (s_next[tail] != 0) tail = s_next[tail];
                        s_next[tail] = 10'(idx);
                        s_prev[idx] = 10'(tail);
                    end
                    live_entries++;
                    st = ST_OK; slot = 10'(idx);
                end
            end else if (f == 0) begin
                st = ST_MISS;
            end else begin
                slot = 10'(f);
                if (req == REQ_GET) begin
                    if ((s_flags[f] & ungettable_mask) != 0) begin
                        st = ST_UNGETTABLE;
                    end else begin
                        s_hits[f]++;
                        st = ST_OK; rv = s_val[f]; rl = s_vlen[f]; rh = s_hits[f];
                    end
                end else if (req == REQ_DELETE) begin
                    p = s_prev[f]; n = s_next[f];
                    if (p != 0) s_next[p] = 10'(n);
                    else heads[bucket_of(s_hash[f])] = 10'(n);
                    if (n != 0) s_prev[n] = 10'(p);
                    s_klen[f] = 0; s_vlen[f] = 0; s_hash[f] = 0;
                    s_prev[f] = 0; s_next[f] = 0;
                    if (f + 1 == high_water) begin
                        high_water--;
                    end else if (free_top + 1 < 1024) begin
                        free_top++;
                        free_slots[free_top] = 10'(f);
                    end
                    live_entries--;
                    st = ST_OK;
                end else begin
                    st = ST_OK;
                end
            end
        end
        exp_status.push_back(st); exp_slot.push_back(slot);
        exp_value.push_back(rv); exp_length.push_back(rl); exp_hits.push_back(rh);
    endfunction

    // Compare one accepted result against the oldest prediction.
    function void check_result(logic [2:0] st, logic [9:0] slot, logic [63:0] rv,
                               logic [3:0] rl, logic [31:0] rh);
        logic [2:0]  es;
        logic [9:0]  ei;
        logic [63:0] ev;
        logic [3:0]  el;
        logic [31:0] eh;
        results_seen++;
        if (exp_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result, status %0d", st);
            return;
        end
        es = exp_status.pop_front(); ei = exp_slot.pop_front();
        ev = exp_value.pop_front(); el = exp_length.pop_front(); eh = exp_hits.pop_front();
        if (st !== es || slot !== ei || rv !== ev || rl !== el || rh !== eh) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: result %0d expected st=%0d slot=%0d val=%h len=%0d ",
                          "hits=%0d, got st=%0d slot=%0d val=%h len=%0d hits=%0d"},
                         results_seen, es, ei, ev, el, eh, st, slot, rv, rl, rh);
        end
    endfunction
endclass

module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_key_bytes = '0;
    logic [3:0]  i_key_length = '0;
    logic [63:0] i_value_word = '0;
    logic [3:0]  i_value_length = '0;
    logic [31:0] i_lifetime = '0;
    logic [31:0] i_now_time = '0;
    logic [15:0] i_entry_flags = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [9:0]  o_slot_index;
    logic [63:0] o_read_value;
    logic [3:0]  o_read_length;
    logic [31:0] o_hit_count;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    cache_scoreboard board;
    bit no_idle;
    int requests_sent;
    logic [63:0] key_pool [16];
    logic [63:0] chain_keys [3];

    hashed_key_value_cache dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, checks each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_status, o_slot_index, o_read_value, o_read_length,
                               o_hit_count);
    end

    always @(negedge i_clk) begin
        i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // Send one request and wait for its acceptance. Valid is low on entry,
    // so the first falling edge here never repeats the previous drop of valid.
    task automatic send_request(t_req req, logic [63:0] kb, logic [3:0] kl,
                                logic [63:0] vw, logic [3:0] vl, logic [15:0] fl);
        do @(negedge i_clk); while (!no_idle && $urandom_range(99) < 23);
        i_valid <= 1'b1; i_req_type <= req; i_key_bytes <= kb; i_key_length <= kl;
        i_value_word <= vw; i_value_length <= vl; i_entry_flags <= fl;
        i_lifetime <= $urandom; i_now_time <= $urandom;
        do @(posedge i_clk); while (!(o_ready && i_valid));
        board.note_request(req, kb, kl, vw, vl, fl);
        requests_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Write one register once all results are back and the block is idle.
    task automatic write_register(logic idx, logic [15:0] data);
        while (board.exp_status.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CAPACITY) board.capacity = data[10:0];
        else board.ungettable_mask = data;
    endtask

    // Search three-byte keys that land in one bucket so that chains get walked.
    task automatic find_chain_keys();
        int target;
        int found;
        logic [63:0] k;
        chain_keys[0] = 64'h1;
        target = board.bucket_of(board.djb_hash(chain_keys[0], 3));
        found = 1;
        for (int v = 2; v < (1 << 24) && found < 3; v++) begin
            k = 64'(v);
            if (board.bucket_of(board.djb_hash(k, 3)) == target) begin
                chain_keys[found] = k;
                found++;
            end
        end
    endtask

    // Random request biased toward keys from a small pool so hits occur.
    task automatic random_request();
        logic [63:0] kb;
        logic [3:0]  kl;
        int r;
        r = $urandom_range(99);
        kb = (r < 85) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
        kl = (r < 5) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
        if ($urandom_range(9) == 0) kl = 4'($urandom_range(8, 1));
        send_request(t_req'($urandom_range(3)), kb, kl, {$urandom, $urandom},
                     ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(8, 1)),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0);
    endtask

    initial begin
        board = new();
        board.clear_state();
        board.mismatches = 0;
        board.results_seen = 0;
        requests_sent = 0;
        no_idle = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: extremes, every request type, special cases.
        send_request(REQ_GET, 64'h0, 4'd0, 64'h0, 4'd1, 16'h0);
        send_request(REQ_SET, 64'h1, 4'd9, 64'h0, 4'd1, 16'h0);
        send_request(REQ_SET, 64'hff, 4'd1, '1, 4'd0, 16'h0);
        send_request(REQ_SET, 64'hff, 4'd1, '1, 4'd9, 16'h0);
        send_request(REQ_SET, 64'hff, 4'd1, '1, 4'd8, 16'hffff);
        send_request(REQ_SET, '1, 4'd8, '1, 4'd8, 16'h0);
        send_request(REQ_SET, 64'hff, 4'd1, 64'h5, 4'd1, 16'h0);
        send_request(REQ_GET, 64'hff, 4'd1, 64'h0, 4'd1, 16'h0);
        send_request(REQ_GET, '1, 4'd8, 64'h0, 4'd1, 16'h0);
        send_request(REQ_GET, '1, 4'd8, 64'h0, 4'd1, 16'h0);
        send_request(REQ_EXISTS, '1, 4'd8, 64'h0, 4'd1, 16'h0);
        send_request(REQ_EXISTS, 64'h7f, 4'd1, 64'h0, 4'd1, 16'h0);
        send_request(REQ_SET, 64'h1234_5678, 4'd4, 64'h00ab, 4'd3, 16'h4);
        send_request(REQ_DELETE, 64'hff, 4'd1, 64'h0, 4'd1, 16'h0);
        send_request(REQ_DELETE, 64'hff, 4'd1, 64'h0, 4'd1, 16'h0);
        send_request(REQ_DELETE, 64'h1234_5678, 4'd4, 64'h0, 4'd1, 16'h0);
        send_request(REQ_SET, 64'h80, 4'd1, 64'h1, 4'd1, 16'h0);
        send_request(REQ_GET, 64'h80, 4'd1, 64'h0, 4'd1, 16'h0);

        // Shared bucket: walk a chain, delete its head, its tail, then re-add.
        find_chain_keys();
        for (int i = 0; i < 3; i++)
            send_request(REQ_SET, chain_keys[i], 4'd3, 64'(i + 1), 4'd2, 16'h0);
        send_request(REQ_GET, chain_keys[2], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_DELETE, chain_keys[0], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_GET, chain_keys[1], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_GET, chain_keys[2], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_DELETE, chain_keys[2], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_SET, chain_keys[0], 4'd3, 64'h9, 4'd1, 16'h0);
        send_request(REQ_EXISTS, chain_keys[0], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_DELETE, chain_keys[1], 4'd3, 64'h0, 4'd1, 16'h0);
        send_request(REQ_GET, chain_keys[0], 4'd3, 64'h0, 4'd1, 16'h0);

        // Tiny capacity: fill, hit full, then free and reuse.
        write_register(CFG_UNGETTABLE, 16'h0);
        write_register(CFG_CAPACITY, 16'd2);
        send_request(REQ_SET, 64'h55, 4'd1, 64'h1, 4'd1, 16'h2);
        send_request(REQ_GET, '1, 4'd8, 64'h0, 4'd1, 16'h0);
        send_request(REQ_DELETE, '1, 4'd8, 64'h0, 4'd1, 16'h0);
        send_request(REQ_SET, 64'h55, 4'd1, 64'h1, 4'd1, 16'h2);
        send_request(REQ_SET, 64'h56, 4'd1, 64'h1, 4'd1, 16'h2);

        // Random phases across capacities and masks.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_CAPACITY, 16'd6);
                    write_register(CFG_UNGETTABLE, 16'hffff);
                end
                1: begin
                    write_register(CFG_CAPACITY, 16'd2047);
                    write_register(CFG_UNGETTABLE, 16'd2);
                    no_idle = 1'b1;
                end
                2: begin
                    write_register(CFG_CAPACITY, 16'd1);
                    no_idle = 1'b0;
                end
                3: write_register(CFG_CAPACITY, 16'd24);
                default: write_register(CFG_CAPACITY, 16'd1024);
            endcase
            repeat (200) random_request();
        end

        while (board.exp_status.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d requests and checked %0d results", requests_sent,
                 board.results_seen);
        $display("over shared buckets and several capacity and mask settings.");
        if (board.mismatches == 0 && board.exp_status.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", board.mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard limit: clearing pass plus a generous bound per request.
    initial begin
        #20ms;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end
endmodule
